FILE: src/assert_macros.svh
// assertion macros used by the priority queue rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge, disabled while in reset
`define SRPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define SRPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/srpq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies
package srpq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int CAP_W        = 5;
    localparam int OCC_W        = 5;
    localparam int CMP_W        = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic
    {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // per-cell control from the chain
    typedef struct packed
    {
        logic enq;
        logic deq;
        logic occupied;
        logic tail;
    } cell_ctrl_t;

    // one result transaction
    typedef struct packed
    {
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic                    out_valid;
        status_t                 status;
        logic [OCC_W-1:0]        occupancy;
    } result_t;

endpackage

FILE: src/srpq_cell.sv
// one slot of the sorted chain: compares its key and shifts with neighbors
// depends on srpq_pkg
module srpq_cell
    import srpq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_gt,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       gt
);

    entry_t entry_reg;
    entry_t entry_next;

    // held entry sorts after the incoming key
    assign gt    = ctrl.occupied && (entry_reg.key > new_entry.key);
    assign entry = entry_reg;

    // insert shifts up, dequeue shifts down
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || ctrl.tail)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    // entry storage (key and payload), undefined until written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: src/srpq_chain.sv
// row of cells with the entry counter and full/empty decisions
// depends on srpq_pkg, srpq_cell and assert_macros.svh
`include "assert_macros.svh"

module srpq_chain
    import srpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_en,
    input  kind_t            kind,
    input  entry_t           new_entry,
    input  logic [CAP_W-1:0] capacity,
    output result_t          result
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    logic             do_enq;
    logic             do_deq;

    entry_t     cell_entry [DEPTH];
    logic       cell_gt    [DEPTH];
    cell_ctrl_t cell_ctrl  [DEPTH];

    // limit is min(capacity, DEPTH)
    assign full   = (CMP_W'(count_reg) >= CMP_W'(capacity))
                 || (CMP_W'(count_reg) >= CMP_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_enq = op_en && (kind == KIND_ENQ) && !full;
    assign do_deq = op_en && (kind == KIND_DEQ) && !empty;

    // the row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_gt;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        assign cell_ctrl[i].enq      = do_enq;
        assign cell_ctrl[i].deq      = do_deq;
        assign cell_ctrl[i].occupied = (CNT_W'(i) < count_reg);
        assign cell_ctrl[i].tail     = (CNT_W'(i) == count_reg);

        srpq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // entry counter
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result of the current transaction
    always_comb
    begin
        result.out_key     = '0;
        result.out_payload = '0;
        result.out_valid   = 1'b0;
        result.status      = ST_DONE;
        result.occupancy   = OCC_W'(count_next);
        if (kind == KIND_ENQ)
        begin
            if (full)
            begin
                result.status = ST_FULL;
            end
        end
        else
        begin
            if (empty)
            begin
                result.status = ST_EMPTY;
            end
            else
            begin
                result.out_key     = cell_entry[0].key;
                result.out_payload = cell_entry[0].payload;
                result.out_valid   = 1'b1;
            end
        end
    end

    `SRPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `SRPQ_ASSERT(a_enq_count, do_enq |=> count_reg == $past(count_reg) + CNT_W'(1), "enqueue did not add an entry")
    `SRPQ_ASSERT(a_deq_count, do_deq |=> count_reg == $past(count_reg) - CNT_W'(1), "dequeue did not remove an entry")
    `SRPQ_ASSERT(a_refuse_hold, (op_en && !do_enq && !do_deq) |=> $stable(count_reg), "refused operation changed the count")

endmodule

FILE: src/sorted_ring_priority_queue.sv
// sorted priority queue: each transaction is an enqueue or a dequeue, one result each
// the result is registered at the edge that accepts the input transaction
// throughput: one transaction per cycle if not stalled; all cells compare and shift
// reset: entry count clears to empty, capacity returns to 16; slot contents stay undefined
// depends on srpq_pkg and srpq_chain
module sorted_ring_priority_queue
    import srpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    kind,
    input  logic [KEY_BITS-1:0]     entry_key,
    input  logic [PAYLOAD_BITS-1:0] entry_payload,
    // result channel
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [KEY_BITS-1:0]     out_key,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic                    out_valid,
    output logic [1:0]              status,
    output logic [OCC_W-1:0]        occupancy
);

    logic [CAP_W-1:0] capacity_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    result_t          result_reg;
    result_t          result;
    logic             accept;
    entry_t           new_entry;

    // configuration register, decoded at every address with paddr[2] low
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(16);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // transaction accept, the result register frees each cycle it is taken
    assign in_stall        = res_valid_reg && res_stall;
    assign accept          = in_valid && !in_stall;
    assign new_entry.key     = entry_key;
    assign new_entry.payload = entry_payload;

    srpq_chain u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_en     (accept),
        .kind      (kind_t'(kind)),
        .new_entry (new_entry),
        .capacity  (capacity_reg),
        .result    (result)
    );

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_key     = result_reg.out_key;
    assign out_payload = result_reg.out_payload;
    assign out_valid   = result_reg.out_valid;
    assign status      = result_reg.status;
    assign occupancy   = result_reg.occupancy;

endmodule
